// ----- rtl/core/vdk3_pkg.sv -----
package vdk3_pkg;

  localparam int DEF_BLOCK_LEN   = 64;
  localparam int DEF_SOFT_BITS   = 8;
  localparam int DEF_METRIC_BITS = 16;

  // Port widths fixed by the interface.
  localparam int SOFT_W = 8;
  localparam int BIDX_W = 6;

  typedef enum logic [1:0] {
    ST_ACS,
    ST_RD,
    ST_EMIT
  } vdk3_state_t;

  typedef struct packed {
    logic acs;
    logic rd;
    logic emit;
  } vdk3_cmd_t;

  typedef struct packed {
    logic last_item;
    logic idx_zero;
    logic out_free;
  } vdk3_stat_t;

  // Code bits of the branch leaving predecessor prev with input bit u.
  // Bit 0 selects soft_a, bit 1 soft_b, bit 2 soft_c.
  function automatic logic [2:0] code_mask(input logic [1:0] prev, input logic u);
    logic [2:0] m;
    unique case ({prev, u})
      3'b000:  m = 3'b000;
      3'b001:  m = 3'b101;
      3'b010:  m = 3'b111;
      3'b011:  m = 3'b010;
      3'b100:  m = 3'b100;
      3'b101:  m = 3'b001;
      3'b110:  m = 3'b011;
      default: m = 3'b110;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/viterbi_decoder_k3_rate_third.sv -----
// Channel  | Direction | Handshake              | Word
// in_      | input     | in_valid / in_ready    | soft_a, soft_b, soft_c, block_end
// out_     | output    | out_valid / out_ready  | bit_index, decoded_bit, final_bit
//
// Add-compare-select over the four states completes in the cycle in which
// each input word is taken.
// After the last word of a block the survivor memory is traced back from
// state 0, each decoded bit by a memory read and then an output load, so a
// block of N words gives N output words, with no input taken meanwhile.
// The single output register stalls the traceback while out_ready is low.
// Reset: state 0 metric zero, the others unreachable, word count zero.
module viterbi_decoder_k3_rate_third #(
  parameter int BLOCK_LEN   = vdk3_pkg::DEF_BLOCK_LEN,
  parameter int SOFT_BITS   = vdk3_pkg::DEF_SOFT_BITS,
  parameter int METRIC_BITS = vdk3_pkg::DEF_METRIC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [vdk3_pkg::SOFT_W-1:0] in_soft_a,
  input  logic signed [vdk3_pkg::SOFT_W-1:0] in_soft_b,
  input  logic signed [vdk3_pkg::SOFT_W-1:0] in_soft_c,
  input  logic                               in_block_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vdk3_pkg::BIDX_W-1:0]        out_bit_index,
  output logic                               out_decoded_bit,
  output logic                               out_final_bit
);
  import vdk3_pkg::*;

  vdk3_cmd_t  cmd;
  vdk3_stat_t stat;

  vdk3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vdk3_datapath #(
    .BLOCK_LEN   (BLOCK_LEN),
    .SOFT_BITS   (SOFT_BITS),
    .METRIC_BITS (METRIC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_soft_a       (in_soft_a),
    .in_soft_b       (in_soft_b),
    .in_soft_c       (in_soft_c),
    .in_block_end    (in_block_end),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit_index   (out_bit_index),
    .out_decoded_bit (out_decoded_bit),
    .out_final_bit   (out_final_bit)
  );

endmodule

// ----- rtl/core/vdk3_ctrl.sv -----
module vdk3_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vdk3_pkg::vdk3_stat_t stat,
  output vdk3_pkg::vdk3_cmd_t  cmd
);
  import vdk3_pkg::*;

  vdk3_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACS;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_ACS: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acs = 1'b1;
          if (stat.last_item) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.idx_zero ? ST_ACS : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_ACS;
      end
    endcase
  end

endmodule

// ----- rtl/core/vdk3_datapath.sv -----
module vdk3_datapath #(
  parameter int BLOCK_LEN   = vdk3_pkg::DEF_BLOCK_LEN,
  parameter int SOFT_BITS   = vdk3_pkg::DEF_SOFT_BITS,
  parameter int METRIC_BITS = vdk3_pkg::DEF_METRIC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [vdk3_pkg::SOFT_W-1:0] in_soft_a,
  input  logic signed [vdk3_pkg::SOFT_W-1:0] in_soft_b,
  input  logic signed [vdk3_pkg::SOFT_W-1:0] in_soft_c,
  input  logic                              in_block_end,
  input  vdk3_pkg::vdk3_cmd_t               cmd,
  output vdk3_pkg::vdk3_stat_t              stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vdk3_pkg::BIDX_W-1:0]       out_bit_index,
  output logic                              out_decoded_bit,
  output logic                              out_final_bit
);
  import vdk3_pkg::*;

  localparam int AW    = $clog2(BLOCK_LEN);
  localparam int SCW   = $clog2(BLOCK_LEN + 1);
  localparam int CW    = METRIC_BITS + SOFT_BITS + 4;
  localparam int RAW_W = (SOFT_BITS > SOFT_W) ? SOFT_BITS : SOFT_W;
  localparam logic [METRIC_BITS-1:0] PM_MAX = {METRIC_BITS{1'b1}};

  logic [METRIC_BITS-1:0] pm_r [4];
  logic [METRIC_BITS-1:0] pm_nxt [4];
  logic [SCW-1:0]         step_r;
  logic [3:0]             surv;
  logic [3:0]             mem [BLOCK_LEN];
  logic [3:0]             rd_data_r;
  logic [AW-1:0]          tb_idx_r;
  logic [1:0]             tb_st_r;
  logic                   out_valid_r;
  logic [BIDX_W-1:0]      out_bit_index_r;
  logic                   out_decoded_r;
  logic                   out_final_r;

  logic [RAW_W-1:0]     raw [3];
  logic signed [CW-1:0] smp [3];
  logic signed [CW-1:0] cand [4][2];
  logic signed [CW-1:0] best [4];
  logic signed [CW-1:0] sum;
  logic signed [CW-1:0] minv;
  logic signed [CW-1:0] diff;
  logic                 reach [4];
  logic                 rp [2];
  logic                 any;
  logic [2:0]           mask;

  // Only the low SOFT_BITS bits of a sample count; wider settings see the
  // port value zero-extended.
  always_comb begin
    raw[0] = RAW_W'($unsigned(in_soft_a));
    raw[1] = RAW_W'($unsigned(in_soft_b));
    raw[2] = RAW_W'($unsigned(in_soft_c));
    for (int k = 0; k < 3; k++) begin
      smp[k] = CW'(signed'(raw[k][SOFT_BITS-1:0]));
    end
  end

  always_comb begin
    surv = '0;
    any  = 1'b0;
    minv = '0;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < 2; d++) begin
        mask = code_mask(2'(((s % 2) * 2) + d), 1'(s / 2));
        sum  = (mask[0] ? smp[0] : CW'(0)) + (mask[1] ? smp[1] : CW'(0))
             + (mask[2] ? smp[2] : CW'(0));
        rp[d] = (pm_r[((s % 2) * 2) + d] != PM_MAX);
        cand[s][d] = CW'($signed({1'b0, pm_r[((s % 2) * 2) + d]})) - (sum <<< 1);
      end
      // On equal cost the lower predecessor keeps the survivor.
      if (rp[1] && (!rp[0] || (cand[s][1] < cand[s][0]))) begin
        surv[s] = 1'b1;
        best[s] = cand[s][1];
      end else begin
        best[s] = cand[s][0];
      end
      reach[s] = rp[0] || rp[1];
      if (reach[s] && (!any || (best[s] < minv))) begin
        minv = best[s];
        any  = 1'b1;
      end
    end
    for (int s = 0; s < 4; s++) begin
      diff = best[s] - minv;
      if (!reach[s] || (diff >= CW'($signed({1'b0, PM_MAX})))) begin
        pm_nxt[s] = PM_MAX;
      end else begin
        pm_nxt[s] = diff[METRIC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r[0] <= '0;
      pm_r[1] <= PM_MAX;
      pm_r[2] <= PM_MAX;
      pm_r[3] <= PM_MAX;
      step_r  <= '0;
    end else if (cmd.acs) begin
      // The last word of a block restarts the trellis at once; the
      // survivors it leaves behind are read out before new words come in.
      if (stat.last_item) begin
        pm_r[0] <= '0;
        pm_r[1] <= PM_MAX;
        pm_r[2] <= PM_MAX;
        pm_r[3] <= PM_MAX;
        step_r  <= '0;
      end else begin
        pm_r   <= pm_nxt;
        step_r <= step_r + SCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acs) begin
      mem[step_r[AW-1:0]] <= surv;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[tb_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acs && stat.last_item) begin
      tb_idx_r <= step_r[AW-1:0];
      tb_st_r  <= 2'b00;
    end else if (cmd.emit) begin
      tb_idx_r <= tb_idx_r - AW'(1);
      tb_st_r  <= {tb_st_r[0], rd_data_r[tb_st_r]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bit_index_r <= BIDX_W'(tb_idx_r);
      out_decoded_r   <= tb_st_r[1];
      out_final_r     <= (tb_idx_r == '0);
    end
  end

  assign stat.last_item = in_block_end || (step_r == SCW'(BLOCK_LEN - 1));
  assign stat.idx_zero  = (tb_idx_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_bit_index   = out_bit_index_r;
  assign out_decoded_bit = out_decoded_r;
  assign out_final_bit   = out_final_r;

endmodule
